// ===== rtl/scpc_pkg.sv =====
// Shared types and constants for the second-chance page cache controller.
`timescale 1ns / 1ps
package scpc_pkg;

	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;
	localparam int PAGE_W = 32;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_SYNC  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACCESS = 2'd0,
		KIND_WB     = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	typedef struct packed {
		logic  load;
		logic  touch;
		logic  second;
		logic  evict;
		logic  install;
		logic  sync_clr;
		logic  sync_step;
		logic  sync_wb;
		logic  emit;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic hit;
		logic need_evict;
		logic empty;
		logic back_used;
		logic sync_last;
		logic best_found;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/scpc_dp.sv =====
// Datapath: page tags, recency ranks, flags, sync walk and result register.
`timescale 1ns / 1ps
module scpc_dp #(
	parameter int SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [scpc_pkg::CAP_W-1:0]    cfg_wdata,
	input  logic [1:0]                    in_op,
	input  logic [scpc_pkg::PAGE_W-1:0]   in_page,
	input  scpc_pkg::cmd_t                cmd,
	output scpc_pkg::sts_t                sts,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [scpc_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast
);
	import scpc_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [PAGE_W-1:0] slot_page [SLOTS];
	logic [SLOTS-1:0]  valid_q, dirty_q, used_q;
	logic [IDX_W-1:0]  rank_q [SLOTS];
	logic [CNT_W-1:0]  count_q;
	logic [CAP_W-1:0]  cap_q;

	logic [PAGE_W-1:0] page_q;
	logic              wr_q;
	op_t               op_q;
	logic              hit_q, ev_valid_q, ev_dirty_q;
	logic [PAGE_W-1:0] ev_page_q;

	logic [IDX_W-1:0]  sync_idx_q, best_idx_q;
	logic              best_found_q;
	logic [PAGE_W-1:0] best_page_q;

	logic              out_valid_q, out_hit_q, out_ev_q, out_dirty_q, out_last_q;
	logic [PAGE_W-1:0] out_page_q;
	kind_t             out_kind_q;

	logic              hit_any, back_any, free_any, out_free;
	logic [IDX_W-1:0]  hit_idx, back_idx, free_idx, front_idx, old_rank;
	logic [IDX_W-1:0]  last_rank;
	logic              sync_cand;

	assign last_rank = IDX_W'(count_q - CNT_W'(1));

	// Parallel tag match, back-of-list lookup and first free slot.
	always_comb begin
		hit_any  = 1'b0;
		back_any = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		back_idx = '0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && slot_page[i] == page_q) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (valid_q[i] && rank_q[i] == last_rank) begin
				back_any = 1'b1;
				back_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign front_idx = cmd.touch ? hit_idx : back_idx;
	assign old_rank  = rank_q[front_idx];
	assign sync_cand = valid_q[sync_idx_q] && dirty_q[sync_idx_q] &&
		(!best_found_q || slot_page[sync_idx_q] < best_page_q);
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		sts.op         = op_q;
		sts.hit        = hit_any;
		sts.need_evict = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q == CNT_W'(SLOTS));
		sts.empty      = (count_q == '0) || !back_any;
		sts.back_used  = used_q[back_idx];
		sts.sync_last  = (sync_idx_q == IDX_W'(SLOTS - 1));
		sts.best_found = best_found_q;
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.install && free_any)
			slot_page[free_idx] <= page_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			used_q  <= '0;
			count_q <= '0;
			cap_q   <= CAP_RESET;
			for (int i = 0; i < SLOTS; i++)
				rank_q[i] <= '0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (cmd.touch || cmd.second) begin
				for (int i = 0; i < SLOTS; i++)
					if (valid_q[i] && rank_q[i] < old_rank)
						rank_q[i] <= rank_q[i] + IDX_W'(1);
				rank_q[front_idx] <= '0;
				used_q[front_idx] <= cmd.touch;
				if (cmd.touch && wr_q)
					dirty_q[front_idx] <= 1'b1;
			end
			if (cmd.evict) begin
				valid_q[back_idx] <= 1'b0;
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.install && free_any) begin
				for (int i = 0; i < SLOTS; i++)
					if (valid_q[i])
						rank_q[i] <= rank_q[i] + IDX_W'(1);
				rank_q[free_idx]  <= '0;
				valid_q[free_idx] <= 1'b1;
				used_q[free_idx]  <= 1'b1;
				dirty_q[free_idx] <= wr_q;
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.sync_wb)
				dirty_q[best_idx_q] <= 1'b0;
		end
	end

	// Item latch, eviction record and sync walk registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= OP_NONE;
			wr_q         <= 1'b0;
			page_q       <= '0;
			hit_q        <= 1'b0;
			ev_valid_q   <= 1'b0;
			ev_dirty_q   <= 1'b0;
			ev_page_q    <= '0;
			sync_idx_q   <= '0;
			best_idx_q   <= '0;
			best_found_q <= 1'b0;
			best_page_q  <= '0;
		end else begin
			if (cmd.load) begin
				op_q       <= op_t'(in_op);
				wr_q       <= (op_t'(in_op) == OP_WRITE);
				page_q     <= in_page;
				hit_q      <= 1'b0;
				ev_valid_q <= 1'b0;
				ev_dirty_q <= 1'b0;
				ev_page_q  <= '0;
			end
			if (cmd.touch)
				hit_q <= 1'b1;
			if (cmd.evict) begin
				ev_valid_q <= 1'b1;
				ev_dirty_q <= dirty_q[back_idx];
				ev_page_q  <= slot_page[back_idx];
			end
			if (cmd.sync_clr) begin
				sync_idx_q   <= '0;
				best_found_q <= 1'b0;
			end else if (cmd.sync_step) begin
				sync_idx_q <= sync_idx_q + IDX_W'(1);
				if (sync_cand) begin
					best_found_q <= 1'b1;
					best_idx_q   <= sync_idx_q;
					best_page_q  <= slot_page[sync_idx_q];
				end
			end
		end
	end

	// Result register: load on emit, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_ACCESS;
			out_hit_q   <= 1'b0;
			out_ev_q    <= 1'b0;
			out_page_q  <= '0;
			out_dirty_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
			out_kind_q  <= cmd.kind;
			case (cmd.kind)
				KIND_ACCESS: begin
					out_hit_q   <= hit_q;
					out_ev_q    <= ev_valid_q;
					out_page_q  <= ev_page_q;
					out_dirty_q <= ev_dirty_q;
					out_last_q  <= 1'b1;
				end
				KIND_WB: begin
					out_hit_q   <= 1'b0;
					out_ev_q    <= 1'b0;
					out_page_q  <= best_page_q;
					out_dirty_q <= 1'b1;
					out_last_q  <= 1'b0;
				end
				default: begin
					out_hit_q   <= 1'b0;
					out_ev_q    <= 1'b0;
					out_page_q  <= '0;
					out_dirty_q <= 1'b0;
					out_last_q  <= 1'b1;
				end
			endcase
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_dirty_q, out_page_q, out_ev_q, out_hit_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS)) else $error("resident count above slot count");
	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'($countones(valid_q)) == count_q) else $error("count and valid bits disagree");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free) else $error("result overwritten before taken");
	a_install_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.install |-> free_any) else $error("install with no free slot");

endmodule

// ===== rtl/scpc_ctrl.sv =====
// Controller state machine sequencing lookups, eviction scans and sync walks.
`timescale 1ns / 1ps
module scpc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  scpc_pkg::sts_t sts,
	output scpc_pkg::cmd_t cmd
);
	import scpc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_SCAN, ST_INSTALL, ST_EMIT_ACC,
		ST_SYNC_SCAN, ST_SYNC_DEC, ST_SYNC_WB, ST_SYNC_DONE
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.kind = KIND_ACCESS;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.op == OP_SYNC) begin
					cmd.sync_clr = 1'b1;
					state_d      = ST_SYNC_SCAN;
				end else if (sts.op == OP_NONE) begin
					state_d = ST_IDLE;
				end else if (sts.hit) begin
					cmd.touch = 1'b1;
					state_d   = ST_EMIT_ACC;
				end else if (sts.need_evict) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_INSTALL;
				end
			end
			ST_SCAN: begin
				// used page: clear its bit and move it to the front, look again
				if (sts.empty) begin
					state_d = ST_INSTALL;
				end else if (sts.back_used) begin
					cmd.second = 1'b1;
				end else begin
					cmd.evict = 1'b1;
					state_d   = ST_INSTALL;
				end
			end
			ST_INSTALL: begin
				cmd.install = 1'b1;
				state_d     = ST_EMIT_ACC;
			end
			ST_EMIT_ACC: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SYNC_SCAN: begin
				cmd.sync_step = 1'b1;
				if (sts.sync_last)
					state_d = ST_SYNC_DEC;
			end
			ST_SYNC_DEC: begin
				state_d = sts.best_found ? ST_SYNC_WB : ST_SYNC_DONE;
			end
			ST_SYNC_WB: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.kind     = KIND_WB;
					cmd.sync_wb  = 1'b1;
					cmd.sync_clr = 1'b1;
					state_d      = ST_SYNC_SCAN;
				end
			end
			ST_SYNC_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_DONE;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_one_scan_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.second && cmd.evict)) else $error("second chance and evict together");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_DECODE)) else $error("load did not enter decode");
	a_wb_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.kind == KIND_WB) |-> sts.best_found)
		else $error("writeback without a dirty page");

endmodule

// ===== rtl/second_chance_page_cache_controller_top.sv =====
// Top level of the second-chance page cache tag and replacement controller.
//
//  channel  | signals                         | contents (low bit first)
//  ---------+---------------------------------+-------------------------------------------
//  s_axis   | s_tvalid s_tready s_tdata s_tuser| tdata: page_number[31:0]; tuser: op[1:0]
//  m_axis   | m_tvalid m_tready m_tdata m_tuser| tdata: hit, evicted_valid, out_page[31:0],
//           | m_tlast                         |   out_dirty, zero pad; tuser: kind; tlast
//  config   | cfg_we cfg_wdata                | cache_capacity[4:0]
//
// A hit passes through decode and result emit; a miss adds an install step, and when it must
// evict, a second-chance scan of up to SLOTS+1 page visits from the back of the list.
// A sync walks all slots once per written-back page, plus a final walk that finds none.
// Reset clears all valid, dirty and used flags, ranks and the count; capacity returns to 4.
// New words are taken only when idle; a stalled result holds the sequencer in place.
`timescale 1ns / 1ps
module second_chance_page_cache_controller_top #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,   // cache_capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // page_number
	input  logic [1:0]  s_tuser,     // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,     // hit, evicted_valid, out_page, out_dirty, pad
	output logic [1:0]  m_tuser,     // kind
	output logic        m_tlast
);
	import scpc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	scpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scpc_dp #(.SLOTS(SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_op     (s_tuser),
		.in_page   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
